// ===== hdl/npma_pkg.sv =====
`timescale 1ns / 1ps

package npma_pkg;

  // defaults for the top-level parameters
  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 32;

  // fixed field widths
  localparam int CFG_W    = 11;
  localparam int IDX_W    = 10;
  localparam int POS_W    = 32;
  localparam int VAL_W    = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  // packed stream widths
  localparam int S_TDATA_W = 144;
  localparam int M_TDATA_W = 48;

  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ACCUM = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MAX_RD,
    ST_MAX_UPD,
    ST_FINISH
  } state_t;

endpackage

// ===== hdl/npma_dist.sv =====
`timescale 1ns / 1ps

// Squared distance pipeline, four register stages:
// abs diff -> split partial products -> per-axis square -> three-way sum.
module npma_dist
  import npma_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ADDR_W     = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [ADDR_W-1:0]         in_index,
  input  logic [3*COORD_BITS-1:0]   pt_xyz,     // x lowest
  input  logic [3*COORD_BITS-1:0]   q_xyz,      // x lowest
  output logic                      out_valid,
  output logic [ADDR_W-1:0]         out_index,
  output logic [2*COORD_BITS+3:0]   out_dist,
  output logic                      busy
);

  localparam int CW     = COORD_BITS;
  localparam int D      = CW + 1;
  localparam int L      = (D + 1) / 2;
  localparam int H      = D - L;
  localparam int SQ_W   = 2 * D;
  localparam int DIST_W = 2 * D + 2;

  logic [D-1:0]     diff [3];
  logic [D-1:0]     absd [3];

  logic             v1, v2, v3;
  logic [ADDR_W-1:0] i1, i2, i3;
  logic [D-1:0]     a1 [3];
  logic [2*L-1:0]   pll [3];
  logic [L+H-1:0]   phl [3];
  logic [2*H-1:0]   phh [3];
  logic [SQ_W-1:0]  sq [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {pt_xyz[k*CW+CW-1], pt_xyz[k*CW +: CW]}
              - {q_xyz[k*CW+CW-1], q_xyz[k*CW +: CW]};
      absd[k] = diff[k][D-1] ? (~diff[k] + D'(1)) : diff[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    i1 <= in_index;
    i2 <= i1;
    i3 <= i2;
    out_index <= i3;
    for (int k = 0; k < 3; k++) begin
      a1[k]  <= absd[k];
      // a = h*2^L + l ; a^2 = h^2*2^2L + 2hl*2^L + l^2
      pll[k] <= (2*L)'(a1[k][L-1:0]) * (2*L)'(a1[k][L-1:0]);
      phl[k] <= (L+H)'(a1[k][D-1:L]) * (L+H)'(a1[k][L-1:0]);
      phh[k] <= (2*H)'(a1[k][D-1:L]) * (2*H)'(a1[k][D-1:L]);
      sq[k]  <= (SQ_W'(phh[k]) << (2*L)) + (SQ_W'(phl[k]) << (L+1)) + SQ_W'(pll[k]);
    end
    out_dist <= DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
  end

  assign busy = v1 | v2 | v3 | out_valid;

endmodule

// ===== hdl/nearest_point_max_accumulator_unit.sv =====
`timescale 1ns / 1ps
// Load and error items go from decode to finish, read items also through max read and max
//   update; an accumulate scans n = min(points_in_use, MAX_POINTS) points first.
// Throughput: one item at a time; the accumulate scan reads one point per cycle from the
//   coordinate RAM (single read port).
// Reset (rst, synchronous): control, points_in_use and m_tvalid clear; the point
//   RAMs are not cleared, an entry is defined once loaded.
module nearest_point_max_accumulator_unit
  import npma_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // point_index, pos_x, pos_y, pos_z, sample_value
  input  logic [FUNC_W-1:0]     s_tuser,   // func
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // hit_index, max_value
  output logic [STATUS_W-1:0]   m_tuser,   // status
  // config: points_in_use
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int CW     = COORD_BITS;
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = ($clog2(MAX_POINTS + 1) > CFG_W) ? $clog2(MAX_POINTS + 1) : CFG_W;
  localparam int DIST_W = 2 * (CW + 1) + 2;

  // ---------------------------------------------------------------------------
  // Storage: coordinates in one wide RAM, running maxima in a second RAM.
  // Both read synchronously into registered read data.
  // ---------------------------------------------------------------------------
  logic [3*CW-1:0]  coord_mem [MAX_POINTS];
  logic [VAL_W-1:0] max_mem   [MAX_POINTS];
  logic [3*CW-1:0]  coord_rdata;
  logic [VAL_W-1:0] max_rdata;

  state_t state, state_next;

  logic [CFG_W-1:0]  points_in_use;
  logic [CNT_W-1:0]  eff_n;

  // transaction being worked on
  func_t             it_func;
  logic [IDX_W-1:0]  it_idx;
  logic [3*CW-1:0]   it_q;        // query coordinates, x lowest
  logic [VAL_W-1:0]  it_val;
  logic [CNT_W-1:0]  idx_ext;
  logic [ADDR_W-1:0] it_addr;

  // scan
  logic [CNT_W-1:0]  scan_cnt;
  logic [ADDR_W-1:0] scan_addr;
  logic              rd_valid;
  logic [ADDR_W-1:0] rd_index;
  logic              dist_valid;
  logic [ADDR_W-1:0] dist_index;
  logic [DIST_W-1:0] scan_dist;
  logic              dist_busy;
  logic [DIST_W-1:0] best_d;
  logic [ADDR_W-1:0] best_addr;
  logic              scan_done;

  // decode of the held transaction
  status_t           dec_status;
  logic [IDX_W-1:0]  dec_hit;

  // control strobes
  logic              coord_we;
  logic              max_we;
  logic [ADDR_W-1:0] max_addr;
  logic [VAL_W-1:0]  max_wdata;
  logic              scan_start;
  logic              scan_issue;
  logic              res_set;
  status_t           res_status_next;
  logic [IDX_W-1:0]  res_hit_next;
  logic [VAL_W-1:0]  res_mval_next;
  logic              out_load;
  logic              raise;

  status_t           res_status;
  logic [IDX_W-1:0]  res_hit;
  logic [VAL_W-1:0]  res_mval;

  // clamp register to table size
  assign eff_n = (CNT_W'(points_in_use) > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                              : CNT_W'(points_in_use);
  assign idx_ext   = CNT_W'(it_idx);
  assign it_addr   = idx_ext[ADDR_W-1:0];
  assign scan_addr = scan_cnt[ADDR_W-1:0];
  assign scan_done = (scan_cnt == eff_n) && !rd_valid && !dist_busy;
  assign raise     = $signed(it_val) > $signed(max_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= '0;
    end else if (cfg_we) begin
      points_in_use <= cfg_wdata;
    end
  end

  // capture the input transaction; coordinates wrap or sign-extend to CW bits
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      it_func <= func_t'(s_tuser);
      it_idx  <= s_tdata[9:0];
      it_q    <= {CW'($signed(s_tdata[105:74])),
                  CW'($signed(s_tdata[73:42])),
                  CW'($signed(s_tdata[41:10]))};
      it_val  <= s_tdata[137:106];
    end
  end

  // error classification
  always_comb begin
    dec_status = STAT_OK;
    dec_hit    = it_idx;
    case (it_func)
      FUNC_LOAD, FUNC_READ: begin
        if (eff_n == '0) begin
          dec_status = STAT_EMPTY;
        end else if (idx_ext >= eff_n) begin
          dec_status = STAT_RANGE;
        end
      end
      FUNC_ACCUM: begin
        dec_hit = '0;
        if (eff_n == '0) begin
          dec_status = STAT_EMPTY;
        end
      end
      default: begin
        dec_status = STAT_RANGE;
        dec_hit    = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (dec_status != STAT_OK) begin
          state_next = ST_FINISH;
        end else begin
          case (it_func)
            FUNC_ACCUM: state_next = ST_SCAN;
            FUNC_READ:  state_next = ST_MAX_RD;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_MAX_RD;
        end
      end
      ST_MAX_RD:  state_next = ST_MAX_UPD;
      ST_MAX_UPD: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready        = 1'b0;
    coord_we        = 1'b0;
    max_we          = 1'b0;
    max_addr        = it_addr;
    max_wdata       = it_val;
    scan_start      = 1'b0;
    scan_issue      = 1'b0;
    res_set         = 1'b0;
    res_status_next = STAT_OK;
    res_hit_next    = it_idx;
    res_mval_next   = '0;
    out_load        = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DECODE: begin
        if (dec_status != STAT_OK) begin
          res_set         = 1'b1;
          res_status_next = dec_status;
          res_hit_next    = dec_hit;
        end else if (it_func == FUNC_LOAD) begin
          coord_we      = 1'b1;
          max_we        = 1'b1;
          max_wdata     = VAL_MIN;
          res_set       = 1'b1;
          res_mval_next = VAL_MIN;
        end else if (it_func == FUNC_ACCUM) begin
          scan_start = 1'b1;
        end
      end
      ST_SCAN: scan_issue = (scan_cnt < eff_n);
      ST_MAX_RD: begin
        if (it_func == FUNC_ACCUM) begin
          max_addr = best_addr;
        end
      end
      ST_MAX_UPD: begin
        res_set = 1'b1;
        if (it_func == FUNC_ACCUM) begin
          max_addr      = best_addr;
          max_we        = raise;
          res_hit_next  = IDX_W'(best_addr);
          res_mval_next = raise ? it_val : max_rdata;
        end else begin
          res_mval_next = max_rdata;
        end
      end
      ST_FINISH: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // RAM ports
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (coord_we) begin
      coord_mem[it_addr] <= it_q;
    end
    coord_rdata <= coord_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (max_we) begin
      max_mem[max_addr] <= max_wdata;
    end
    max_rdata <= max_mem[max_addr];
  end

  // ---------------------------------------------------------------------------
  // Scan: one coordinate read per cycle into the distance pipeline
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (scan_start) begin
        scan_cnt <= '0;
      end else if (scan_issue) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      rd_valid <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_index <= scan_addr;
  end

  npma_dist #(
    .COORD_BITS (COORD_BITS),
    .ADDR_W     (ADDR_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_index  (rd_index),
    .pt_xyz    (coord_rdata),
    .q_xyz     (it_q),
    .out_valid (dist_valid),
    .out_index (dist_index),
    .out_dist  (scan_dist),
    .busy      (dist_busy)
  );

  // running minimum; strict less keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (dist_valid && ((dist_index == '0) || (scan_dist < best_d))) begin
      best_d    <= scan_dist;
      best_addr <= dist_index;
    end
  end

  // ---------------------------------------------------------------------------
  // Result hold and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (res_set) begin
      res_status <= res_status_next;
      res_hit    <= res_hit_next;
      res_mval   <= res_mval_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(M_TDATA_W - IDX_W - VAL_W)'(0), res_mval, res_hit};
      m_tuser <= res_status;
    end
  end

endmodule

// ===== sim/nearest_point_max_accumulator_unit_tb.sv =====
`timescale 1ns / 1ps

module nearest_point_max_accumulator_unit_tb;
  import npma_pkg::*;

  // selector code the block must reject
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = VAL_MIN;
  localparam logic [31:0] Q_NEG5 = 32'hFFFF_FFFB;
  localparam logic [31:0] Q_NEG6 = 32'hFFFF_FFFA;

  localparam int NO_CFG      = -1;
  localparam int DIR_N       = 22;
  localparam int PHASE_N     = 10;
  localparam int HOLD_CYCLES = 300;
  // worst accumulate is a full 1024-entry scan plus overhead
  localparam int TAIL_CYCLES = 1100;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       x, y, z, v;
  } item_t;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] hit;
    logic [31:0]      maxv;
  } max_result_t;

  typedef struct {
    int                cfg;    // NO_CFG: no register write ahead of this row
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       x, y, z, v;
    bit                typed;  // result typed in below, else from the predictor
    status_t           st;
    logic [IDX_W-1:0]  hit;
    logic [31:0]       mx;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // point_index, pos_x, pos_y, pos_z, sample_value
  logic [FUNC_W-1:0]    s_tuser;   // func
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // hit_index, max_value
  logic [STATUS_W-1:0]  m_tuser;   // status
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_wdata;

  nearest_point_max_accumulator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns period
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the point table and of points_in_use.
  // entry_loaded keeps stimulus away from entries never written.
  // ---------------------------------------------------------------------------
  logic signed [31:0] pt_x   [MAX_POINTS_DEF];
  logic signed [31:0] pt_y   [MAX_POINTS_DEF];
  logic signed [31:0] pt_z   [MAX_POINTS_DEF];
  logic        [31:0] pt_max [MAX_POINTS_DEF];
  bit                 entry_loaded [MAX_POINTS_DEF];
  logic [CFG_W-1:0]   points_cfg;

  max_result_t awaited_answers[$];

  int cycle_count;
  int mismatches;
  int n_sent, n_checked, n_accum, n_err_answers, n_settings;
  int send_idle_pct, recv_idle_pct;
  int hold_asks, hold_served;

  function automatic int unsigned points_searched();
    return (points_cfg > MAX_POINTS_DEF) ? MAX_POINTS_DEF : points_cfg;
  endfunction

  // exact squared Euclidean distance; 3 * (2^32-1)^2 fits in 68 bits
  function automatic logic [67:0] sq_dist(input logic signed [31:0] ax, ay, az,
                                          input logic signed [31:0] bx, by, bz);
    logic signed [33:0] dx, dy, dz;
    logic [67:0]        ux, uy, uz;
    dx = ax - bx;
    dy = ay - by;
    dz = az - bz;
    ux = (dx < 0) ? 68'(-dx) : 68'(dx);
    uy = (dy < 0) ? 68'(-dy) : 68'(dy);
    uz = (dz < 0) ? 68'(-dz) : 68'(dz);
    return ux * ux + uy * uy + uz * uz;
  endfunction

  // Applies one transaction to the predictor state and returns its answer.
  function automatic max_result_t predict_nearest_max(input item_t it);
    max_result_t r;
    int unsigned eff;
    int unsigned best;
    int unsigned i;
    logic [67:0] d, best_d;
    r   = '{STAT_OK, '0, '0};
    eff = points_searched();
    if (it.func == FUNC_UNUSED) begin
      r.status = STAT_RANGE;
    end else if (eff == 0) begin
      r.status = STAT_EMPTY;
      r.hit    = (it.func == FUNC_ACCUM) ? '0 : it.idx;
    end else if (it.func == FUNC_ACCUM) begin
      best   = 0;
      best_d = '0;
      for (i = 0; i < eff; i++) begin
        d = sq_dist(pt_x[i], pt_y[i], pt_z[i], it.x, it.y, it.z);
        // strict compare: lowest index wins a tie
        if (i == 0 || d < best_d) begin
          best_d = d;
          best   = i;
        end
      end
      if ($signed(it.v) > $signed(pt_max[best])) pt_max[best] = it.v;
      r.hit  = best[IDX_W-1:0];
      r.maxv = pt_max[best];
    end else if (it.idx >= eff) begin
      r.status = STAT_RANGE;
      r.hit    = it.idx;
    end else begin
      if (it.func == FUNC_LOAD) begin
        pt_x[it.idx]         = it.x;
        pt_y[it.idx]         = it.y;
        pt_z[it.idx]         = it.z;
        pt_max[it.idx]       = VAL_MIN;
        entry_loaded[it.idx] = 1'b1;
      end
      r.hit  = it.idx;
      r.maxv = pt_max[it.idx];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random field values
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_coord();
    int unsigned r;
    logic [31:0] t;
    r = $urandom_range(99);
    if (r < 8) return Q_MAX;
    if (r < 16) return Q_MIN;
    if (r < 56) begin
      // clustered near the origin so that many points compete
      t = $urandom_range(32 * Q_ONE);
      return t - 16 * Q_ONE;
    end
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    logic [31:0] t;
    r = $urandom_range(99);
    if (r < 6) return Q_MAX;
    if (r < 12) return Q_MIN;
    if (r < 45) begin
      t = $urandom_range(8 * Q_ONE);
      return t - 4 * Q_ONE;
    end
    return $urandom;
  endfunction

  // small offset, zero in one case of five: exact hits and ties on purpose
  function automatic logic [31:0] jitter();
    logic [31:0] t;
    t = $urandom_range(4);
    return t - 32'd2;
  endfunction

  function automatic item_t random_item(input int unsigned eff);
    item_t it;
    int unsigned r;
    int unsigned j;
    r = $urandom_range(99);
    if (r < 40)      it.func = FUNC_ACCUM;
    else if (r < 62) it.func = FUNC_LOAD;
    else if (r < 94) it.func = FUNC_READ;
    else             it.func = FUNC_UNUSED;
    // mostly in range; the rest lands anywhere, out of range when eff is small
    if (eff > 0 && $urandom_range(99) < 85) it.idx = IDX_W'($urandom_range(eff - 1));
    else                                    it.idx = IDX_W'($urandom_range(1023));
    if (eff > 0 && $urandom_range(99) < 30) begin
      j    = $urandom_range(eff - 1);
      it.x = pt_x[j] + jitter();
      it.y = pt_y[j] + jitter();
      it.z = pt_z[j] + jitter();
    end else begin
      it.x = pick_coord();
      it.y = pick_coord();
      it.z = pick_coord();
    end
    it.v = pick_value();
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. Inputs move at the falling edge, handshakes are seen at the
  // rising edge. Tasks are entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic offer_transaction(input item_t it, input bit typed,
                                   input max_result_t typed_res);
    max_result_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.func;
    s_tdata  <= {6'd0, it.v, it.z, it.y, it.x, it.idx};
    do @(posedge clk); while (!s_tready);
    p = predict_nearest_max(it);
    awaited_answers.push_back(typed ? typed_res : p);
    n_sent++;
    if (it.func == FUNC_ACCUM) n_accum++;
    if (p.status != STAT_OK) n_err_answers++;
    @(negedge clk);
  endtask

  // sender stops until every predicted answer has come back
  task automatic wait_all_answered();
    s_tvalid <= 1'b0;
    while (awaited_answers.size() != 0) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic set_points_in_use(input int unsigned n);
    cfg_we    <= 1'b1;
    cfg_wdata <= n[CFG_W-1:0];
    @(negedge clk);
    cfg_we     <= 1'b0;
    points_cfg  = n[CFG_W-1:0];
    n_settings++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("MISMATCH cycle %0d: %s got 0x%0h, expected 0x%0h",
               cycle_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold when asked
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    hold_left   = 0;
    hold_served = 0;
    m_tready   <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left   = HOLD_CYCLES;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    max_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch("result with nothing pending, hit_index", 32'(m_tdata[9:0]), 32'd0);
      end else begin
        e = awaited_answers.pop_front();
        n_checked++;
        if (m_tuser !== e.status)
          report_mismatch("status", 32'(m_tuser), 32'(e.status));
        if (m_tdata[9:0] !== e.hit)
          report_mismatch("hit_index", 32'(m_tdata[9:0]), 32'(e.hit));
        if (m_tdata[41:10] !== e.maxv)
          report_mismatch("max_value", m_tdata[41:10], e.maxv);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t    dir_tab [DIR_N];
    int          ph_cfg  [PHASE_N];
    int          ph_len  [PHASE_N];
    item_t       it;
    max_result_t tr;
    int unsigned eff;
    int          p, k, i;

    mismatches    = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_accum       = 0;
    n_err_answers = 0;
    n_settings    = 0;
    hold_asks     = 0;
    points_cfg    = '0;
    send_idle_pct = 23;
    recv_idle_pct = 46;
    for (i = 0; i < MAX_POINTS_DEF; i++) begin
      pt_x[i]         = '0;
      pt_y[i]         = '0;
      pt_z[i]         = '0;
      pt_max[i]       = '0;
      entry_loaded[i] = 1'b0;
    end

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;

    // Directed rows. Table starts empty (points_in_use 0 after reset), then
    // four points: origin, all-max corner, all-min corner, and (2,2,2) which
    // ties with the origin for a query at (1,1,1).
    dir_tab = '{
      '{NO_CFG, FUNC_LOAD,   10'd5,    Q_MAX, Q_MAX, Q_MAX, 32'd0, 1, STAT_EMPTY, 10'd5, 32'd0},
      '{NO_CFG, FUNC_ACCUM,  10'd9,    32'd1, 32'd2, 32'd3, Q_MAX, 1, STAT_EMPTY, 10'd0, 32'd0},
      '{NO_CFG, FUNC_READ,   10'd1023, 32'd0, 32'd0, 32'd0, 32'd0, 1, STAT_EMPTY, 10'd1023,
        32'd0},
      '{NO_CFG, FUNC_UNUSED, 10'd1023, 32'd0, 32'd0, 32'd0, 32'd0, 1, STAT_RANGE, 10'd0, 32'd0},
      '{4,      FUNC_LOAD,   10'd0,    32'd0, 32'd0, 32'd0, 32'd0, 1, STAT_OK, 10'd0, Q_MIN},
      '{NO_CFG, FUNC_LOAD,   10'd1,    Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, STAT_OK, 10'd1, Q_MIN},
      '{NO_CFG, FUNC_LOAD,   10'd2,    Q_MIN, Q_MIN, Q_MIN, 32'd0, 1, STAT_OK, 10'd2, Q_MIN},
      '{NO_CFG, FUNC_LOAD,   10'd3,    2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE, 32'd0,
        1, STAT_OK, 10'd3, Q_MIN},
      // index equal to the count: out of range
      '{NO_CFG, FUNC_LOAD,   10'd4,    32'd0, 32'd0, 32'd0, 32'd0, 1, STAT_RANGE, 10'd4, 32'd0},
      '{NO_CFG, FUNC_READ,   10'd1023, 32'd0, 32'd0, 32'd0, 32'd0, 1, STAT_RANGE, 10'd1023,
        32'd0},
      '{NO_CFG, FUNC_UNUSED, 10'd2,    Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, STAT_RANGE, 10'd0, 32'd0},
      '{NO_CFG, FUNC_ACCUM,  10'd0,    Q_MIN, Q_MIN, Q_MIN, Q_MAX, 0, STAT_OK, 10'd0, 32'd0},
      // value equal to the minimum leaves the maximum alone
      '{NO_CFG, FUNC_ACCUM,  10'd0,    Q_MAX, Q_MAX, Q_MAX, Q_MIN, 0, STAT_OK, 10'd0, 32'd0},
      // equidistant from entries 0 and 3: lower index wins
      '{NO_CFG, FUNC_ACCUM,  10'd0,    Q_ONE, Q_ONE, Q_ONE, Q_NEG5, 0, STAT_OK, 10'd0, 32'd0},
      '{NO_CFG, FUNC_ACCUM,  10'd0,    Q_ONE, Q_ONE, Q_ONE, Q_NEG5, 0, STAT_OK, 10'd0, 32'd0},
      '{NO_CFG, FUNC_ACCUM,  10'd0,    32'd0, 32'd0, 32'd0, Q_NEG6, 0, STAT_OK, 10'd0, 32'd0},
      // largest coordinate differences
      '{NO_CFG, FUNC_ACCUM,  10'd0,    Q_MAX, Q_MIN, Q_MAX, 32'd7, 0, STAT_OK, 10'd0, 32'd0},
      '{NO_CFG, FUNC_READ,   10'd2,    32'd0, 32'd0, 32'd0, 32'd0, 0, STAT_OK, 10'd0, 32'd0},
      '{NO_CFG, FUNC_READ,   10'd1,    32'd0, 32'd0, 32'd0, 32'd0, 0, STAT_OK, 10'd0, 32'd0},
      // reloading an entry puts its maximum back to the minimum
      '{NO_CFG, FUNC_LOAD,   10'd0,    32'd0, 32'd0, 32'd0, Q_MAX, 1, STAT_OK, 10'd0, Q_MIN},
      '{NO_CFG, FUNC_READ,   10'd0,    32'd0, 32'd0, 32'd0, 32'd0, 1, STAT_OK, 10'd0, Q_MIN},
      '{NO_CFG, FUNC_ACCUM,  10'd0,    2 * Q_ONE + 1, Q_ONE, 32'd3, Q_ONE, 0, STAT_OK, 10'd0,
        32'd0}
    };

    // register settings of the random part: 0 empties the table again,
    // later settings shrink the search below what is loaded
    ph_cfg = '{1, 7, 48, 16, 0, 200, 120, 3, 64, 2};
    ph_len = '{30, 50, 40, 40, 20, 40, 40, 40, 40, 22};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    for (i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].cfg != NO_CFG) begin
        wait_all_answered();
        set_points_in_use(dir_tab[i].cfg);
      end
      it = '{dir_tab[i].func, dir_tab[i].idx, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
             dir_tab[i].v};
      tr = '{dir_tab[i].st, dir_tab[i].hit, dir_tab[i].mx};
      offer_transaction(it, dir_tab[i].typed, tr);
    end

    // random part, one register setting per phase
    for (p = 0; p < PHASE_N; p++) begin
      // idle mix: sender-light, then receiver-light, then none at all
      if (p < 4) begin
        send_idle_pct = 23;
        recv_idle_pct = 46;
      end else if (p < 7) begin
        send_idle_pct = 46;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_all_answered();
      set_points_in_use(ph_cfg[p]);
      eff = points_searched();
      // every entry the scan touches must be loaded first
      for (i = 0; i < eff; i++) begin
        if (!entry_loaded[i]) begin
          it = '{FUNC_LOAD, i[IDX_W-1:0], pick_coord(), pick_coord(), pick_coord(),
                 pick_value()};
          offer_transaction(it, 1'b0, tr);
        end
      end
      for (k = 0; k < ph_len[p]; k++) begin
        // long result stall while transactions keep coming: input backs up
        if (p == 1 && k == 5) hold_asks++;
        offer_transaction(random_item(eff), 1'b0, tr);
      end
    end

    wait_all_answered();
    // anything arriving now has no prediction behind it
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d transactions (%0d accumulates, %0d error answers) over %0d settings",
             n_sent, n_accum, n_err_answers, n_settings);
    $display("Checked %0d results, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
